// ===== hw/rtl/midi_track_event_parser_defines.svh =====
// Assertion macros shared by the track event parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define MTEP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mtep_pkg.sv =====
// Types and constants for the MIDI track event parser.
// No dependencies; used by midi_track_event_parser.
package mtep_pkg;

    // Parse phases
    typedef enum logic [3:0] {
        PH_DELTA    = 4'd0,
        PH_STATUS   = 4'd1,
        PH_DATA1    = 4'd2,
        PH_DATA2    = 4'd3,
        PH_SYSLEN   = 4'd4,
        PH_METATYPE = 4'd5,
        PH_METALEN  = 4'd6,
        PH_SKIP     = 4'd7,
        PH_TEMPO    = 4'd8
    } t_phase;

    // Event kinds on the output
    typedef enum logic [2:0] {
        EV_NOTE    = 3'd0,
        EV_CONTROL = 3'd1,
        EV_PROGRAM = 3'd2,
        EV_BEND    = 3'd3,
        EV_TEMPO   = 3'd4,
        EV_END     = 3'd5
    } t_event_kind;

    // Status high nibbles
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_CONTROL   = 4'hB;
    localparam logic [3:0] ST_PROGRAM   = 4'hC;
    localparam logic [3:0] ST_CHAN_AT   = 4'hD;
    localparam logic [3:0] ST_BEND      = 4'hE;

    // Full status and meta codes
    localparam logic [7:0] ST_LAST_CHAN = 8'hEF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_END     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;

    localparam logic [31:0] TEMPO_LEN   = 32'd3;
    localparam logic [13:0] BEND_CENTER = 14'd8192;

endpackage

// ===== hw/rtl/midi_track_event_parser.sv =====
// MIDI track event parser: one track byte per cycle, one decoded event out.
// Each emitted event is held in a registered result word for the master side.
// Throughput: one byte per cycle; the only stall is a held, untaken result word.
// The parse state is updated by a single combinational step from the input word.
// Reset (i_rst_n low, synchronous) clears parse state and drops any held result.
// Depends on mtep_pkg and midi_track_event_parser_defines.svh.
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] track_byte
    input  logic        i_s_tuser,   // [0] first_of_track
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // [3:0] channel, [10:4] first_data,
                                     // [17:11] second_data, [31:18] bend_value,
                                     // [55:32] tempo_micros, [87:56] delta_ticks
    output logic [2:0]  o_m_tuser    // [2:0] event_kind
);

    // State registers
    mtep_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_running, n_running;
    logic [31:0] r_delta, n_delta;
    logic [31:0] r_skip, n_skip;
    logic [7:0]  r_meta, n_meta;
    logic [7:0]  r_cur, n_cur;
    logic [6:0]  r_held, n_held;
    logic [23:0] r_tempo, n_tempo;
    logic        r_ended, n_ended;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_out_kind, n_out_kind;
    logic [3:0]  r_out_ch, n_out_ch;
    logic [6:0]  r_out_d1, n_out_d1;
    logic [6:0]  r_out_d2, n_out_d2;
    logic [13:0] r_out_bend, n_out_bend;
    logic [23:0] r_out_tempo, n_out_tempo;
    logic [31:0] r_out_delta;
    logic        n_emit;

    // Starting state for this byte: a first byte of a track begins from reset values
    mtep_pkg::t_phase w_phase;
    logic [7:0]  w_running;
    logic [31:0] w_delta;
    logic [31:0] w_skip;
    logic        w_ended;
    logic [7:0]  w_byte;
    logic [6:0]  w_low;
    logic [31:0] w_skip_shift;
    logic [31:0] w_skip_dec;
    logic [23:0] w_tempo_shift;
    logic        w_accept;

    // Data byte handling shared by the status and first-data phases
    logic        w_do_data1;
    logic [7:0]  w_d1_status;

    assign w_accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready    = !r_out_valid || i_m_tready;
    assign w_byte        = i_s_tdata;
    assign w_low         = i_s_tdata[6:0];
    assign w_phase       = i_s_tuser ? mtep_pkg::PH_DELTA : r_phase;
    assign w_running     = i_s_tuser ? 8'd0  : r_running;
    assign w_delta       = i_s_tuser ? 32'd0 : r_delta;
    assign w_skip        = i_s_tuser ? 32'd0 : r_skip;
    assign w_ended       = i_s_tuser ? 1'b0  : r_ended;
    assign w_skip_shift  = {w_skip[24:0], w_low};
    assign w_skip_dec    = w_skip - 32'd1;
    assign w_tempo_shift = {r_tempo[15:0], w_byte};

    // Next state and result for one byte
    always_comb begin
        n_phase     = w_phase;
        n_running   = w_running;
        n_delta     = w_delta;
        n_skip      = w_skip;
        n_meta      = i_s_tuser ? 8'd0 : r_meta;
        n_cur       = i_s_tuser ? 8'd0 : r_cur;
        n_held      = i_s_tuser ? 7'd0 : r_held;
        n_tempo     = i_s_tuser ? 24'd0 : r_tempo;
        n_ended     = w_ended;
        n_emit      = 1'b0;
        n_out_kind  = mtep_pkg::EV_NOTE;
        n_out_ch    = 4'd0;
        n_out_d1    = 7'd0;
        n_out_d2    = 7'd0;
        n_out_bend  = 14'd0;
        n_out_tempo = 24'd0;
        w_do_data1  = 1'b0;
        w_d1_status = r_cur;

        if (!w_ended) begin
            unique case (w_phase)
                mtep_pkg::PH_DELTA: begin
                    n_delta = {w_delta[24:0], w_low};
                    if (!w_byte[7]) begin
                        n_phase = mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    if (!w_byte[7]) begin
                        // Running status, or drop the byte when there is none
                        if (w_running != 8'd0) begin
                            n_cur       = w_running;
                            w_d1_status = w_running;
                            w_do_data1  = 1'b1;
                        end
                    end else begin
                        n_cur = w_byte;
                        if (w_byte <= mtep_pkg::ST_LAST_CHAN) begin
                            n_running = w_byte;
                            n_phase   = mtep_pkg::PH_DATA1;
                        end else if (w_byte == mtep_pkg::ST_SYSEX ||
                                     w_byte == mtep_pkg::ST_SYSEX_ESC) begin
                            n_skip  = 32'd0;
                            n_phase = mtep_pkg::PH_SYSLEN;
                        end else if (w_byte == mtep_pkg::ST_META) begin
                            n_phase = mtep_pkg::PH_METATYPE;
                        end else begin
                            n_delta = 32'd0;
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    w_do_data1 = 1'b1;
                end
                mtep_pkg::PH_DATA2: begin
                    n_out_ch = r_cur[3:0];
                    n_out_d1 = r_held;
                    case (r_cur[7:4])
                        mtep_pkg::ST_NOTE_OFF: begin
                            n_emit     = 1'b1;
                            n_out_kind = mtep_pkg::EV_NOTE;
                        end
                        mtep_pkg::ST_NOTE_ON: begin
                            n_emit     = 1'b1;
                            n_out_kind = mtep_pkg::EV_NOTE;
                            n_out_d2   = w_low;
                        end
                        mtep_pkg::ST_CONTROL: begin
                            n_emit     = 1'b1;
                            n_out_kind = mtep_pkg::EV_CONTROL;
                            n_out_d2   = w_low;
                        end
                        mtep_pkg::ST_BEND: begin
                            n_emit     = 1'b1;
                            n_out_kind = mtep_pkg::EV_BEND;
                            n_out_d1   = 7'd0;
                            n_out_bend = {w_low, r_held} - mtep_pkg::BEND_CENTER;
                        end
                        default: begin
                            n_out_ch = 4'd0;
                            n_out_d1 = 7'd0;
                        end
                    endcase
                    n_delta = 32'd0;
                    n_phase = mtep_pkg::PH_DELTA;
                end
                mtep_pkg::PH_SYSLEN: begin
                    n_skip = w_skip_shift;
                    if (!w_byte[7]) begin
                        if (w_skip_shift == 32'd0) begin
                            n_delta = 32'd0;
                            n_phase = mtep_pkg::PH_DELTA;
                        end else begin
                            n_phase = mtep_pkg::PH_SKIP;
                        end
                    end
                end
                mtep_pkg::PH_METATYPE: begin
                    n_meta  = w_byte;
                    n_skip  = 32'd0;
                    n_phase = mtep_pkg::PH_METALEN;
                end
                mtep_pkg::PH_METALEN: begin
                    n_skip = w_skip_shift;
                    if (!w_byte[7]) begin
                        if (r_meta == mtep_pkg::META_END && w_skip_shift == 32'd0) begin
                            n_ended    = 1'b1;
                            n_emit     = 1'b1;
                            n_out_kind = mtep_pkg::EV_END;
                            n_delta    = 32'd0;
                            n_phase    = mtep_pkg::PH_DELTA;
                        end else if (r_meta == mtep_pkg::META_TEMPO &&
                                     w_skip_shift == mtep_pkg::TEMPO_LEN) begin
                            n_tempo = 24'd0;
                            n_phase = mtep_pkg::PH_TEMPO;
                        end else if (w_skip_shift == 32'd0) begin
                            n_delta = 32'd0;
                            n_phase = mtep_pkg::PH_DELTA;
                        end else begin
                            n_phase = mtep_pkg::PH_SKIP;
                        end
                    end
                end
                mtep_pkg::PH_SKIP: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 32'd0) begin
                        n_delta = 32'd0;
                        n_phase = mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_TEMPO: begin
                    n_tempo = w_tempo_shift;
                    n_skip  = w_skip_dec;
                    if (w_skip_dec == 32'd0) begin
                        n_emit      = 1'b1;
                        n_out_kind  = mtep_pkg::EV_TEMPO;
                        n_out_tempo = w_tempo_shift;
                        n_delta     = 32'd0;
                        n_phase     = mtep_pkg::PH_DELTA;
                    end
                end
                default: begin
                    n_delta = 32'd0;
                    n_phase = mtep_pkg::PH_DELTA;
                end
            endcase

            // First data byte: program emits, aftertouch ends quietly, others hold it
            if (w_do_data1) begin
                case (w_d1_status[7:4])
                    mtep_pkg::ST_PROGRAM: begin
                        n_emit     = 1'b1;
                        n_out_kind = mtep_pkg::EV_PROGRAM;
                        n_out_ch   = w_d1_status[3:0];
                        n_out_d1   = w_low;
                        n_delta    = 32'd0;
                        n_phase    = mtep_pkg::PH_DELTA;
                    end
                    mtep_pkg::ST_CHAN_AT: begin
                        n_delta = 32'd0;
                        n_phase = mtep_pkg::PH_DELTA;
                    end
                    default: begin
                        n_held  = w_low;
                        n_phase = mtep_pkg::PH_DATA2;
                    end
                endcase
            end
        end
    end

    // Advance parse state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_running <= 8'd0;
            r_delta   <= 32'd0;
            r_skip    <= 32'd0;
            r_meta    <= 8'd0;
            r_cur     <= 8'd0;
            r_held    <= 7'd0;
            r_tempo   <= 24'd0;
            r_ended   <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_delta   <= n_delta;
            r_skip    <= n_skip;
            r_meta    <= n_meta;
            r_cur     <= n_cur;
            r_held    <= n_held;
            r_tempo   <= n_tempo;
            r_ended   <= n_ended;
        end
    end

    // Hold the result word until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= n_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_out_kind  <= n_out_kind;
            r_out_ch    <= n_out_ch;
            r_out_d1    <= n_out_d1;
            r_out_d2    <= n_out_d2;
            r_out_bend  <= n_out_bend;
            r_out_tempo <= n_out_tempo;
            r_out_delta <= w_delta;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {r_out_delta, r_out_tempo, r_out_bend, r_out_d2, r_out_d1, r_out_ch};

    // Checks on parse state and result ordering
    `MTEP_ASSERT_NEXT(a_first_clears_end, w_accept && i_s_tuser, !r_ended,
        "first byte of a track did not clear the end flag")
    `MTEP_ASSERT_NOW(a_ended_in_delta, r_ended, r_phase == mtep_pkg::PH_DELTA,
        "ended track left outside the delta phase")
    `MTEP_ASSERT_NOW(a_end_event_flagged, r_out_valid && r_out_kind == mtep_pkg::EV_END,
        r_ended, "end-of-track result held without the end flag")
    `MTEP_ASSERT_NOW(a_tempo_count, r_phase == mtep_pkg::PH_TEMPO,
        r_skip != 32'd0 && r_skip <= mtep_pkg::TEMPO_LEN,
        "tempo byte count out of range")

endmodule
